FILE: rtl/srecord_line_encoder_macros.svh
// Assertion macros for the S-record line encoder.
`ifndef SRECORD_LINE_ENCODER_MACROS_SVH
`define SRECORD_LINE_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SRLE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Consequent must hold in the cycle after the antecedent.
`define SRLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SRLE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SRLE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/srle_pkg.sv
// Shared constants, types and helpers of the S-record line encoder.
`default_nettype none
package srle_pkg;

    localparam int BYTES_PER_RECORD = 16;
    localparam int IDX_W = (BYTES_PER_RECORD > 4) ? $clog2(BYTES_PER_RECORD) : 2;
    localparam int PADDR_W = 3;

    localparam logic [31:0] LIMIT_S1 = 32'h0001_0000;
    localparam logic [31:0] LIMIT_S2 = 32'h0100_0000;
    localparam logic [31:0] END_ADDRESS_RESET = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_NL   = 8'h0A;

    typedef enum logic [0:0] {
        REG_START_ADDRESS = 1'b0,
        REG_END_ADDRESS   = 1'b1
    } reg_index_t;

    // alen holds the number of address bytes minus one (1, 2 or 3).
    typedef struct packed {
        logic        go;
        logic [1:0]  alen;
        logic [7:0]  sum;
        logic [31:0] addr;
    } rec_cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CHAR_ZERO + {4'h0, nib};
        end else begin
            r = CHAR_A + {4'h0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/srecord_line_encoder.sv
// S-record line encoder: gathers payload words and emits one text line per record.
//
// Payload words are taken one per cycle while the formatter is idle into a 16-entry
// record buffer held in a synchronous memory. The word that completes a record starts
// the formatter, and the input stalls while the line is sent: 43 to 47 characters
// (type S1, S2 or S3), one per cycle when the output is free. The formatter reads the
// buffer through its one registered read port, addressed with its next byte index.
// Words arriving once the record address reaches end_address are taken and dropped.
// Writing start_address restarts the record sequence and discards a partial record.
`default_nettype none
`include "srecord_line_encoder_macros.svh"
module srecord_line_encoder (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [srle_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [7:0]                   s_data_byte,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [7:0]                   m_character,
    output logic                         m_end_of_line
);

    localparam logic [srle_pkg::IDX_W-1:0] LAST_IDX =
        srle_pkg::IDX_W'(srle_pkg::BYTES_PER_RECORD - 1);

    logic [31:0]                start_addr_reg;
    logic [31:0]                end_addr_reg;
    logic [31:0]                rec_addr_reg;
    logic [srle_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]                 sum_reg;

    logic [7:0] rec_buf_mem [srle_pkg::BYTES_PER_RECORD];
    logic [7:0] rd_data_reg;

    srle_pkg::reg_index_t       reg_idx;
    srle_pkg::rec_cmd_t         cmd;
    logic [srle_pkg::IDX_W-1:0] rd_addr;
    logic                       fmt_busy;
    logic                       cfg_we;
    logic                       accept;
    logic                       take;
    logic                       last;
    logic [7:0]                 sum_new;
    logic [1:0]                 alen;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = srle_pkg::reg_index_t'(paddr[2]);

    always_comb begin
        case (reg_idx)
            srle_pkg::REG_START_ADDRESS: prdata = start_addr_reg;
            srle_pkg::REG_END_ADDRESS:   prdata = end_addr_reg;
            default:                     prdata = '0;
        endcase
    end

    assign s_ready = !fmt_busy;
    assign accept  = s_valid && s_ready;
    // Drop the word once the record address has reached the end address.
    assign take    = accept && (rec_addr_reg < end_addr_reg);
    assign last    = (idx_reg == LAST_IDX);
    assign sum_new = sum_reg + s_data_byte;

    always_comb begin
        if (rec_addr_reg < srle_pkg::LIMIT_S1) begin
            alen = 2'd1;
        end else if (rec_addr_reg < srle_pkg::LIMIT_S2) begin
            alen = 2'd2;
        end else begin
            alen = 2'd3;
        end
    end

    always_comb begin
        cmd.go   = take && last;
        cmd.alen = alen;
        cmd.sum  = sum_new;
        cmd.addr = rec_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= '0;
            end_addr_reg   <= srle_pkg::END_ADDRESS_RESET;
            rec_addr_reg   <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
        end else if (cfg_we) begin
            case (reg_idx)
                srle_pkg::REG_START_ADDRESS: begin
                    start_addr_reg <= pwdata;
                    rec_addr_reg   <= pwdata;
                    idx_reg        <= '0;
                    sum_reg        <= '0;
                end
                srle_pkg::REG_END_ADDRESS: begin
                    end_addr_reg <= pwdata;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            if (last) begin
                idx_reg      <= '0;
                sum_reg      <= '0;
                rec_addr_reg <= rec_addr_reg + 32'(srle_pkg::BYTES_PER_RECORD);
            end else begin
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_new;
            end
        end
    end

    // Writes happen only while collecting; the read port samples rd_addr every cycle.
    always_ff @(posedge aclk) begin
        if (take) begin
            rec_buf_mem[idx_reg] <= s_data_byte;
        end
        rd_data_reg <= rec_buf_mem[rd_addr];
    end

    srle_fmt u_fmt (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_data       (rd_data_reg),
        .rd_addr       (rd_addr),
        .busy          (fmt_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_end_of_line (m_end_of_line)
    );

    `SRLE_ASSERT_NEXT(a_go_starts_line, aclk, aresetn, cmd.go, fmt_busy && !s_ready)
    `SRLE_ASSERT_NEXT(a_go_clears_record, aclk, aresetn, cmd.go, idx_reg == '0 && sum_reg == '0)
    `SRLE_ASSERT_IMP(a_eol_is_newline, aclk, aresetn, m_valid && m_end_of_line, m_character == srle_pkg::CHAR_NL)

endmodule
`default_nettype wire

FILE: rtl/srle_fmt.sv
// Line formatter: walks one record and sends its S-record text a character at a time.
`default_nettype none
module srle_fmt (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire  srle_pkg::rec_cmd_t        cmd,
    input  wire  [7:0]                      rd_data,
    output logic [srle_pkg::IDX_W-1:0]      rd_addr,
    output logic                            busy,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [7:0]                      m_character,
    output logic                            m_end_of_line
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_S     = 8'b0000_0010,
        ST_TYPE  = 8'b0000_0100,
        ST_COUNT = 8'b0000_1000,
        ST_ADDR  = 8'b0001_0000,
        ST_DATA  = 8'b0010_0000,
        ST_SUM   = 8'b0100_0000,
        ST_EOL   = 8'b1000_0000
    } fmt_state_t;

    localparam logic [7:0] BPR_BYTE = 8'(srle_pkg::BYTES_PER_RECORD);
    localparam logic [srle_pkg::IDX_W-1:0] LAST_IDX =
        srle_pkg::IDX_W'(srle_pkg::BYTES_PER_RECORD - 1);

    fmt_state_t                  state_reg, state_next;
    logic                        nib_reg, nib_next;
    logic [srle_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]                  alen_reg, alen_next;
    logic [31:0]                 addr_reg, addr_next;
    logic [7:0]                  chk_reg, chk_next;
    logic                        m_valid_reg;
    logic [7:0]                  m_char_reg, char_next;
    logic                        m_eol_reg, eol_next;

    logic       adv;
    logic [7:0] count_byte;
    logic [7:0] addr_byte;
    logic [7:0] byte_val;
    logic [3:0] nib_val;

    assign busy = (state_reg != ST_IDLE);
    assign adv  = busy && (!m_valid_reg || m_ready);

    assign count_byte = BPR_BYTE + {6'd0, alen_reg} + 8'd2;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    addr_byte = addr_reg[7:0];
            2'd1:    addr_byte = addr_reg[15:8];
            2'd2:    addr_byte = addr_reg[23:16];
            default: addr_byte = addr_reg[31:24];
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_ADDR: byte_val = addr_byte;
            ST_DATA: byte_val = rd_data;
            ST_SUM:  byte_val = ~chk_reg;
            default: byte_val = count_byte;
        endcase
    end

    assign nib_val = nib_reg ? byte_val[3:0] : byte_val[7:4];

    always_comb begin
        state_next = state_reg;
        nib_next   = nib_reg;
        cnt_next   = cnt_reg;
        alen_next  = alen_reg;
        addr_next  = addr_reg;
        chk_next   = chk_reg;
        char_next  = srle_pkg::hex_char(nib_val);
        eol_next   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.go) begin
                    state_next = ST_S;
                    alen_next  = cmd.alen;
                    addr_next  = cmd.addr;
                    chk_next   = BPR_BYTE + {6'd0, cmd.alen} + 8'd2 + cmd.sum;
                end
            end
            ST_S: begin
                char_next = srle_pkg::CHAR_S;
                if (adv) begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE: begin
                char_next = srle_pkg::CHAR_ZERO + {6'd0, alen_reg};
                if (adv) begin
                    state_next = ST_COUNT;
                    nib_next   = 1'b0;
                end
            end
            ST_COUNT: begin
                if (adv) begin
                    nib_next = ~nib_reg;
                    if (nib_reg) begin
                        state_next = ST_ADDR;
                        cnt_next   = srle_pkg::IDX_W'(alen_reg);
                    end
                end
            end
            ST_ADDR: begin
                if (adv) begin
                    nib_next = ~nib_reg;
                    if (nib_reg) begin
                        chk_next = chk_reg + addr_byte;
                        if (cnt_reg == '0) begin
                            state_next = ST_DATA;
                        end else begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
            end
            ST_DATA: begin
                if (adv) begin
                    nib_next = ~nib_reg;
                    if (nib_reg) begin
                        if (cnt_reg == LAST_IDX) begin
                            state_next = ST_SUM;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SUM: begin
                if (adv) begin
                    nib_next = ~nib_reg;
                    if (nib_reg) begin
                        state_next = ST_EOL;
                    end
                end
            end
            ST_EOL: begin
                char_next = srle_pkg::CHAR_NL;
                eol_next  = 1'b1;
                if (adv) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Address the buffer one step ahead so its registered read lines up with the data state.
    assign rd_addr = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nib_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nib_reg   <= nib_next;
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        alen_reg <= alen_next;
        addr_reg <= addr_next;
        chk_reg  <= chk_next;
        if (adv) begin
            m_char_reg <= char_next;
            m_eol_reg  <= eol_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_character   = m_char_reg;
    assign m_end_of_line = m_eol_reg;

endmodule
`default_nettype wire
